[src/mwnf_pkg.sv]
// Shared widths, configuration types and fixed-point helpers for the wall normal flux block.
`timescale 1ns / 1ps

package mwnf_pkg;

    // Fixed-point format of every value on the datapath
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = WORD_BITS + 2;

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int UCFG_BITS      = 31;

    localparam logic [UCFG_BITS-1:0]     ENTHALPY_RESET  = 31'd163840;
    localparam logic [UCFG_BITS-1:0]     REF_SPEED_RESET = 31'd65536;
    localparam logic [CFG_DATA_BITS-1:0] WALL_POT_RESET  = 32'd0;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [SUM_BITS-1:0]  t_sum;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ENTHALPY  = 2'd0,
        CFG_REF_SPEED = 2'd1,
        CFG_WALL_POT  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        t_word hf;
        t_word beta;
        t_word phi;
    } t_cfg;

    // One half in the word format
    localparam t_word ONE_HALF = t_word'(1) <<< (FRAC_BITS - 1);

    localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_BITS-1:0] NEG_LIMIT  = PROD_BITS'(1) << (WORD_BITS - 1);
    localparam logic [PROD_BITS-1:0] POS_LIMIT  = NEG_LIMIT - PROD_BITS'(1);

    localparam t_sum SUM_MAX = t_sum'(POS_LIMIT[WORD_BITS-1:0]);
    localparam t_sum SUM_MIN = -SUM_MAX - t_sum'(1);

    // Magnitude of a signed word; the most negative value maps to 2^(W-1)
    function automatic logic [WORD_BITS-1:0] abs_word(input t_word a);
        logic [WORD_BITS-1:0] u;
        u = a;
        return a[WORD_BITS-1] ? (~u + WORD_BITS'(1)) : u;
    endfunction

    // Round a product magnitude half away from zero, drop the fraction, saturate
    function automatic t_word round_sat(input logic [PROD_BITS-1:0] mag, input logic neg);
        logic [PROD_BITS-1:0] q;
        q = (mag + ROUND_HALF) >> FRAC_BITS;
        if (neg) begin
            if (q > NEG_LIMIT) q = NEG_LIMIT;
            return t_word'(PROD_BITS'(0) - q);
        end
        if (q > POS_LIMIT) q = POS_LIMIT;
        return t_word'(q);
    endfunction

    // Saturate an exact sum back to one word
    function automatic t_word sat_word(input t_sum s);
        if (s > SUM_MAX) return t_word'(SUM_MAX);
        if (s < SUM_MIN) return t_word'(SUM_MIN);
        return t_word'(s);
    endfunction

endpackage

[src/mwnf_cfg.sv]
// Configuration registers: enthalpy factor, reference speed and wall potential.
`timescale 1ns / 1ps

module mwnf_cfg
    import mwnf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output t_cfg                      o_cfg
);

    logic [UCFG_BITS-1:0]     r_hf;
    logic [UCFG_BITS-1:0]     r_beta;
    logic [CFG_DATA_BITS-1:0] r_phi;

    // Write the addressed register; drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hf   <= ENTHALPY_RESET;
            r_beta <= REF_SPEED_RESET;
            r_phi  <= WALL_POT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENTHALPY:  r_hf   <= i_cfg_data[UCFG_BITS-1:0];
                CFG_REF_SPEED: r_beta <= i_cfg_data[UCFG_BITS-1:0];
                CFG_WALL_POT:  r_phi  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Present all values as datapath words
    assign o_cfg.hf   = t_word'({1'b0, r_hf});
    assign o_cfg.beta = t_word'({1'b0, r_beta});
    assign o_cfg.phi  = t_word'(r_phi);

endmodule

[src/mwnf_mul.sv]
// Two-stage fixed-point multiplier lane: magnitude product, then rounding and saturation.
`timescale 1ns / 1ps

module mwnf_mul
    import mwnf_pkg::*;
(
    input  logic       i_clk,
    input  logic [1:0] i_en,
    input  t_word      i_a,
    input  t_word      i_b,
    output t_word      o_y
);

    logic [WORD_BITS-1:0] abs_a;
    logic [WORD_BITS-1:0] abs_b;
    logic [PROD_BITS-1:0] n_mag;
    logic [PROD_BITS-1:0] r_mag;
    logic                 r_neg;
    t_word                r_y;

    // Multiply magnitudes, keep the sign apart
    assign abs_a = abs_word(i_a);
    assign abs_b = abs_word(i_b);
    assign n_mag = PROD_BITS'(abs_a) * PROD_BITS'(abs_b);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_mag <= n_mag;
            r_neg <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
        end
    end

    // Round half away from zero and clamp to one word
    always_ff @(posedge i_clk) begin
        if (i_en[1]) r_y <= round_sat(r_mag, r_neg);
    end

    assign o_y = r_y;

endmodule

[src/mwnf_delay.sv]
// Enabled shift line that carries operands alongside the pipeline stages.
`timescale 1ns / 1ps

module mwnf_delay #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic [DEPTH-1:0] i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // Advance each tap with its own stage enable
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_en[k]) r_tap[k] <= (k == 0) ? i_d : r_tap[(k == 0) ? 0 : k - 1];
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

[src/mhd_wall_normal_flux.sv]
// Throughput: one word per cycle while the master side accepts; twelve register stages,
// four levels of multiplier lanes, each followed by a saturating add stage.
// Each stage advances when it is empty or the next one advances, so bubbles collapse.
// Reset (synchronous, active low) clears all stage valid bits and restores the
// configuration defaults; data registers are not reset.
`timescale 1ns / 1ps

module mhd_wall_normal_flux
    import mwnf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // slave side
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // normal_x, normal_y, density, velocity_x, velocity_y, velocity_z,
    // field_x, field_y, field_z, pressure (32 bits each, lowest first)
    input  logic [10*WORD_BITS-1:0]   i_s_tdata,
    // master side
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // mass_flux, momentum_flux_x, momentum_flux_y, momentum_flux_z,
    // induction_flux_x, induction_flux_y, induction_flux_z, energy_flux,
    // cleaning_flux (32 bits each, lowest first)
    output logic [9*WORD_BITS-1:0]    o_m_tdata,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int STAGES = 12;
    localparam int W      = WORD_BITS;

    // First multiply level lanes
    localparam int L1_UNX  = 0;
    localparam int L1_VNY  = 1;
    localparam int L1_BXNX = 2;
    localparam int L1_BYNY = 3;
    localparam int L1_UU   = 4;
    localparam int L1_VV   = 5;
    localparam int L1_WW   = 6;
    localparam int L1_BXBX = 7;
    localparam int L1_BYBY = 8;
    localparam int L1_BZBZ = 9;
    localparam int L1_UBX  = 10;
    localparam int L1_VBY  = 11;
    localparam int L1_WBZ  = 12;
    localparam int L1_HFP  = 13;
    localparam int L1_NXPH = 14;
    localparam int L1_NYPH = 15;
    localparam int L1_N    = 16;

    // Second multiply level lanes
    localparam int L2_RHOUN = 0;
    localparam int L2_RHOV2 = 1;
    localparam int L2_UNBX  = 2;
    localparam int L2_UNBY  = 3;
    localparam int L2_UNBZ  = 4;
    localparam int L2_BNU   = 5;
    localparam int L2_BNV   = 6;
    localparam int L2_BNW   = 7;
    localparam int L2_BNBX  = 8;
    localparam int L2_BNBY  = 9;
    localparam int L2_BNBZ  = 10;
    localparam int L2_BNBET = 11;
    localparam int L2_BNVB  = 12;
    localparam int L2_N     = 13;

    // Third multiply level lanes
    localparam int L3_RUNU  = 0;
    localparam int L3_RUNV  = 1;
    localparam int L3_RUNW  = 2;
    localparam int L3_HRV2  = 3;
    localparam int L3_CLEAN = 4;
    localparam int L3_N     = 5;

    t_cfg cfg;

    mwnf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage handshake: a stage loads when empty or when its successor loads
    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] stage_en;

    always_comb begin
        stage_en[STAGES-1] = ~r_valid[STAGES-1] | i_m_tready;
        for (int s = STAGES - 2; s >= 0; s--) begin
            stage_en[s] = ~r_valid[s] | stage_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= (r_valid & ~stage_en) |
                       ({r_valid[STAGES-2:0], i_s_tvalid} & stage_en);
        end
    end

    assign o_s_tready = stage_en[0];
    assign o_m_tvalid = r_valid[STAGES-1];

    // Unpack the input word
    t_word in_nx, in_ny, in_rho, in_u, in_v, in_w, in_bx, in_by, in_bz, in_p;

    assign in_nx  = t_word'(i_s_tdata[0*W +: W]);
    assign in_ny  = t_word'(i_s_tdata[1*W +: W]);
    assign in_rho = t_word'(i_s_tdata[2*W +: W]);
    assign in_u   = t_word'(i_s_tdata[3*W +: W]);
    assign in_v   = t_word'(i_s_tdata[4*W +: W]);
    assign in_w   = t_word'(i_s_tdata[5*W +: W]);
    assign in_bx  = t_word'(i_s_tdata[6*W +: W]);
    assign in_by  = t_word'(i_s_tdata[7*W +: W]);
    assign in_bz  = t_word'(i_s_tdata[8*W +: W]);
    assign in_p   = t_word'(i_s_tdata[9*W +: W]);

    // Carry density, velocity and field to the second multiply level, and velocity on to the third
    logic [W-1:0]   rho_q;
    logic [3*W-1:0] uvw_q2;
    logic [3*W-1:0] uvw_q5;
    logic [3*W-1:0] bxyz_q;

    mwnf_delay #(.WIDTH(W), .DEPTH(3)) u_d_rho (
        .i_clk (i_clk), .i_en (stage_en[2:0]), .i_d (in_rho), .o_q (rho_q)
    );
    mwnf_delay #(.WIDTH(3*W), .DEPTH(3)) u_d_uvw_a (
        .i_clk (i_clk), .i_en (stage_en[2:0]), .i_d ({in_w, in_v, in_u}), .o_q (uvw_q2)
    );
    mwnf_delay #(.WIDTH(3*W), .DEPTH(3)) u_d_uvw_b (
        .i_clk (i_clk), .i_en (stage_en[5:3]), .i_d (uvw_q2), .o_q (uvw_q5)
    );
    mwnf_delay #(.WIDTH(3*W), .DEPTH(3)) u_d_bxyz (
        .i_clk (i_clk), .i_en (stage_en[2:0]), .i_d ({in_bz, in_by, in_bx}), .o_q (bxyz_q)
    );

    t_word d2_rho, d2_u, d2_v, d2_w, d2_bx, d2_by, d2_bz, d5_u, d5_v, d5_w;

    assign d2_rho = t_word'(rho_q);
    assign d2_u   = t_word'(uvw_q2[0*W +: W]);
    assign d2_v   = t_word'(uvw_q2[1*W +: W]);
    assign d2_w   = t_word'(uvw_q2[2*W +: W]);
    assign d5_u   = t_word'(uvw_q5[0*W +: W]);
    assign d5_v   = t_word'(uvw_q5[1*W +: W]);
    assign d5_w   = t_word'(uvw_q5[2*W +: W]);
    assign d2_bx  = t_word'(bxyz_q[0*W +: W]);
    assign d2_by  = t_word'(bxyz_q[1*W +: W]);
    assign d2_bz  = t_word'(bxyz_q[2*W +: W]);

    // First multiply level: products of raw inputs and configuration values (stages 0 and 1)
    t_word l1_a [L1_N];
    t_word l1_b [L1_N];
    t_word l1_y [L1_N];

    always_comb begin
        l1_a[L1_UNX]  = in_u;   l1_b[L1_UNX]  = in_nx;
        l1_a[L1_VNY]  = in_v;   l1_b[L1_VNY]  = in_ny;
        l1_a[L1_BXNX] = in_bx;  l1_b[L1_BXNX] = in_nx;
        l1_a[L1_BYNY] = in_by;  l1_b[L1_BYNY] = in_ny;
        l1_a[L1_UU]   = in_u;   l1_b[L1_UU]   = in_u;
        l1_a[L1_VV]   = in_v;   l1_b[L1_VV]   = in_v;
        l1_a[L1_WW]   = in_w;   l1_b[L1_WW]   = in_w;
        l1_a[L1_BXBX] = in_bx;  l1_b[L1_BXBX] = in_bx;
        l1_a[L1_BYBY] = in_by;  l1_b[L1_BYBY] = in_by;
        l1_a[L1_BZBZ] = in_bz;  l1_b[L1_BZBZ] = in_bz;
        l1_a[L1_UBX]  = in_u;   l1_b[L1_UBX]  = in_bx;
        l1_a[L1_VBY]  = in_v;   l1_b[L1_VBY]  = in_by;
        l1_a[L1_WBZ]  = in_w;   l1_b[L1_WBZ]  = in_bz;
        l1_a[L1_HFP]  = cfg.hf; l1_b[L1_HFP]  = in_p;
        l1_a[L1_NXPH] = in_nx;  l1_b[L1_NXPH] = cfg.phi;
        l1_a[L1_NYPH] = in_ny;  l1_b[L1_NYPH] = cfg.phi;
    end

    for (genvar k = 0; k < L1_N; k++) begin : g_l1
        mwnf_mul u_mul (
            .i_clk (i_clk), .i_en (stage_en[1:0]),
            .i_a (l1_a[k]), .i_b (l1_b[k]), .o_y (l1_y[k])
        );
    end

    // Stage 2: normal velocity, normal field, squares and dot product
    t_word r_un, r_bn, r_v2, r_b2, r_vb, r_hfp, r_nxphi, r_nyphi;

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_un    <= sat_word(t_sum'(l1_y[L1_UNX]) + t_sum'(l1_y[L1_VNY]));
            r_bn    <= sat_word(t_sum'(l1_y[L1_BXNX]) + t_sum'(l1_y[L1_BYNY]));
            r_v2    <= sat_word(t_sum'(l1_y[L1_UU]) + t_sum'(l1_y[L1_VV])
                                + t_sum'(l1_y[L1_WW]));
            r_b2    <= sat_word(t_sum'(l1_y[L1_BXBX]) + t_sum'(l1_y[L1_BYBY])
                                + t_sum'(l1_y[L1_BZBZ]));
            r_vb    <= sat_word(t_sum'(l1_y[L1_UBX]) + t_sum'(l1_y[L1_VBY])
                                + t_sum'(l1_y[L1_WBZ]));
            r_hfp   <= l1_y[L1_HFP];
            r_nxphi <= l1_y[L1_NXPH];
            r_nyphi <= l1_y[L1_NYPH];
        end
    end

    // Second multiply level (stages 3 and 4)
    t_word l2_a [L2_N];
    t_word l2_b [L2_N];
    t_word l2_y [L2_N];

    always_comb begin
        l2_a[L2_RHOUN] = d2_rho; l2_b[L2_RHOUN] = r_un;
        l2_a[L2_RHOV2] = d2_rho; l2_b[L2_RHOV2] = r_v2;
        l2_a[L2_UNBX]  = r_un;   l2_b[L2_UNBX]  = d2_bx;
        l2_a[L2_UNBY]  = r_un;   l2_b[L2_UNBY]  = d2_by;
        l2_a[L2_UNBZ]  = r_un;   l2_b[L2_UNBZ]  = d2_bz;
        l2_a[L2_BNU]   = r_bn;   l2_b[L2_BNU]   = d2_u;
        l2_a[L2_BNV]   = r_bn;   l2_b[L2_BNV]   = d2_v;
        l2_a[L2_BNW]   = r_bn;   l2_b[L2_BNW]   = d2_w;
        l2_a[L2_BNBX]  = r_bn;   l2_b[L2_BNBX]  = d2_bx;
        l2_a[L2_BNBY]  = r_bn;   l2_b[L2_BNBY]  = d2_by;
        l2_a[L2_BNBZ]  = r_bn;   l2_b[L2_BNBZ]  = d2_bz;
        l2_a[L2_BNBET] = r_bn;   l2_b[L2_BNBET] = cfg.beta;
        l2_a[L2_BNVB]  = r_bn;   l2_b[L2_BNVB]  = r_vb;
    end

    for (genvar k = 0; k < L2_N; k++) begin : g_l2
        mwnf_mul u_mul (
            .i_clk (i_clk), .i_en (stage_en[4:3]),
            .i_a (l2_a[k]), .i_b (l2_b[k]), .o_y (l2_y[k])
        );
    end

    // Carry stage 2 terms forward
    logic [2*W-1:0] nphi_q;
    logic [2*W-1:0] hb_q;
    logic [W-1:0]   un_q;

    mwnf_delay #(.WIDTH(2*W), .DEPTH(2)) u_d_nphi (
        .i_clk (i_clk), .i_en (stage_en[4:3]), .i_d ({r_nyphi, r_nxphi}), .o_q (nphi_q)
    );
    mwnf_delay #(.WIDTH(2*W), .DEPTH(5)) u_d_hb (
        .i_clk (i_clk), .i_en (stage_en[7:3]), .i_d ({r_b2, r_hfp}), .o_q (hb_q)
    );
    mwnf_delay #(.WIDTH(W), .DEPTH(6)) u_d_un (
        .i_clk (i_clk), .i_en (stage_en[8:3]), .i_d (r_un), .o_q (un_q)
    );

    // Stage 5: mass flux and the induction fluxes
    t_word r_rhoun, r_rhov2, r_bnbeta, r_ind_x, r_ind_y, r_ind_z;

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_rhoun  <= l2_y[L2_RHOUN];
            r_rhov2  <= l2_y[L2_RHOV2];
            r_bnbeta <= l2_y[L2_BNBET];
            r_ind_x  <= sat_word(t_sum'(l2_y[L2_UNBX]) - t_sum'(l2_y[L2_BNU])
                                 + t_sum'(t_word'(nphi_q[0*W +: W])));
            r_ind_y  <= sat_word(t_sum'(l2_y[L2_UNBY]) - t_sum'(l2_y[L2_BNV])
                                 + t_sum'(t_word'(nphi_q[1*W +: W])));
            r_ind_z  <= sat_word(t_sum'(l2_y[L2_UNBZ]) - t_sum'(l2_y[L2_BNW]));
        end
    end

    logic [3*W-1:0] bnb_q;
    logic [W-1:0]   bnvb_q;
    logic [4*W-1:0] early_q;

    mwnf_delay #(.WIDTH(3*W), .DEPTH(3)) u_d_bnb (
        .i_clk (i_clk), .i_en (stage_en[7:5]),
        .i_d ({l2_y[L2_BNBZ], l2_y[L2_BNBY], l2_y[L2_BNBX]}), .o_q (bnb_q)
    );
    mwnf_delay #(.WIDTH(W), .DEPTH(6)) u_d_bnvb (
        .i_clk (i_clk), .i_en (stage_en[10:5]), .i_d (l2_y[L2_BNVB]), .o_q (bnvb_q)
    );
    mwnf_delay #(.WIDTH(4*W), .DEPTH(5)) u_d_early (
        .i_clk (i_clk), .i_en (stage_en[10:6]),
        .i_d ({r_ind_z, r_ind_y, r_ind_x, r_rhoun}), .o_q (early_q)
    );

    // Third multiply level (stages 6 and 7)
    t_word l3_a [L3_N];
    t_word l3_b [L3_N];
    t_word l3_y [L3_N];

    always_comb begin
        l3_a[L3_RUNU]  = r_rhoun;  l3_b[L3_RUNU]  = d5_u;
        l3_a[L3_RUNV]  = r_rhoun;  l3_b[L3_RUNV]  = d5_v;
        l3_a[L3_RUNW]  = r_rhoun;  l3_b[L3_RUNW]  = d5_w;
        l3_a[L3_HRV2]  = ONE_HALF; l3_b[L3_HRV2]  = r_rhov2;
        l3_a[L3_CLEAN] = r_bnbeta; l3_b[L3_CLEAN] = cfg.beta;
    end

    for (genvar k = 0; k < L3_N; k++) begin : g_l3
        mwnf_mul u_mul (
            .i_clk (i_clk), .i_en (stage_en[7:6]),
            .i_a (l3_a[k]), .i_b (l3_b[k]), .o_y (l3_y[k])
        );
    end

    // Stage 8: momentum fluxes, enthalpy sum and cleaning flux
    t_word r_mom_x, r_mom_y, r_mom_z, r_hsum, r_clean;

    always_ff @(posedge i_clk) begin
        if (stage_en[8]) begin
            r_mom_x <= sat_word(t_sum'(l3_y[L3_RUNU]) - t_sum'(t_word'(bnb_q[0*W +: W])));
            r_mom_y <= sat_word(t_sum'(l3_y[L3_RUNV]) - t_sum'(t_word'(bnb_q[1*W +: W])));
            r_mom_z <= sat_word(t_sum'(l3_y[L3_RUNW]) - t_sum'(t_word'(bnb_q[2*W +: W])));
            r_hsum  <= sat_word(t_sum'(t_word'(hb_q[0*W +: W])) + t_sum'(l3_y[L3_HRV2])
                                + t_sum'(t_word'(hb_q[1*W +: W])));
            r_clean <= l3_y[L3_CLEAN];
        end
    end

    logic [4*W-1:0] late_q;

    mwnf_delay #(.WIDTH(4*W), .DEPTH(2)) u_d_late (
        .i_clk (i_clk), .i_en (stage_en[10:9]),
        .i_d ({r_clean, r_mom_z, r_mom_y, r_mom_x}), .o_q (late_q)
    );

    // Fourth multiply level (stages 9 and 10): normal velocity times enthalpy sum
    t_word unh_y;

    mwnf_mul u_l4_mul (
        .i_clk (i_clk), .i_en (stage_en[10:9]),
        .i_a (r_hsum), .i_b (t_word'(un_q)), .o_y (unh_y)
    );

    // Stage 11: energy flux and the output word register
    t_word r_out [9];

    always_ff @(posedge i_clk) begin
        if (stage_en[11]) begin
            r_out[0] <= t_word'(early_q[0*W +: W]);
            r_out[1] <= t_word'(late_q[0*W +: W]);
            r_out[2] <= t_word'(late_q[1*W +: W]);
            r_out[3] <= t_word'(late_q[2*W +: W]);
            r_out[4] <= t_word'(early_q[1*W +: W]);
            r_out[5] <= t_word'(early_q[2*W +: W]);
            r_out[6] <= t_word'(early_q[3*W +: W]);
            r_out[7] <= sat_word(t_sum'(unh_y) - t_sum'(t_word'(bnvb_q)));
            r_out[8] <= t_word'(late_q[3*W +: W]);
        end
    end

    // Pack the result word, first field lowest
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_m_tdata[k*W +: W] = r_out[k];
        end
    end

endmodule
